@@ rtl/spf_pkg.sv @@
// Shared types and constants for the scanline span filler.
package spf_pkg;

    localparam int MaxVertices = 16;
    localparam int CoordBits   = 10;
    localparam int SpanLimit   = 8;
    localparam int VidxBits    = $clog2(MaxVertices);
    localparam int VcntBits    = $clog2(MaxVertices + 1);
    localparam int QueueDepth  = 2;

    typedef logic [CoordBits-1:0] coord_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FILL   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        op_t    op;
        coord_t vx;
        coord_t vy;
        coord_t sy;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_MUL,
        ST_DIV,
        ST_SORT,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/scanline_polygon_span_fill.sv @@
// Top level of the scanline polygon span filler.
// Clear and append are carried out in the back end after the queue.
// A fill walks the edges, sorts the crossings and emits the spans, and skips the walk off the box;
// each sloped edge is worked out by the bit-serial divider.
// One fill is worked at a time; the front queue holds two further words.
// Reset clears the polygon, box, queue and output register.
module scanline_polygon_span_fill (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operation, vertex_x, vertex_y, scan_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // span_y, span_x_start, span_x_end
    output logic        m_axis_tuser,  // span_valid
    output logic        m_axis_tlast
);
    import spf_pkg::*;

    cmd_t                 in_cmd, q_cmd;
    logic                 q_valid, q_ready;
    logic [CoordBits-1:0] span_y, span_x_end;
    logic [CoordBits:0]   span_x_start;

    assign in_cmd.op = op_t'(s_axis_tdata[1:0]);
    assign in_cmd.vx = s_axis_tdata[11:2];
    assign in_cmd.vy = s_axis_tdata[21:12];
    assign in_cmd.sy = s_axis_tdata[31:22];

    spf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    spf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .span_y       (span_y),
        .span_x_start (span_x_start),
        .span_x_end   (span_x_end),
        .span_valid   (m_axis_tuser),
        .last_span    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, span_x_end, span_x_start, span_y};

    a_empty_no_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("span-less word without last");
    a_zero_no_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:10] == '0)
        else $error("span-less word carries coordinates");

endmodule

@@ rtl/spf_front.sv @@
// Input side: accepts words, filters unknown operations, queues commands.
module spf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  spf_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output spf_pkg::cmd_t q_cmd
);
    import spf_pkg::*;

    localparam int PtrBits = $clog2(QueueDepth);

    cmd_t                 mem_reg [QueueDepth];
    logic [PtrBits-1:0]   wr_reg;
    logic [PtrBits-1:0]   rd_reg;
    logic [PtrBits:0]     cnt_reg;
    logic                 push;
    logic                 pop;

    assign in_ready = (cnt_reg != QueueDepth[PtrBits:0]);
    assign push     = in_valid && in_ready && (in_cmd.op != OP_NONE);
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{PtrBits{1'b0}}, push} - {{PtrBits{1'b0}}, pop};
        end
    end

endmodule

@@ rtl/spf_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module spf_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2*spf_pkg::CoordBits:0] num,
    input  logic [spf_pkg::CoordBits-1:0] den,
    output logic                        done,
    output logic [spf_pkg::CoordBits-1:0] quo
);
    import spf_pkg::*;

    localparam int NumBits = 2 * CoordBits + 1;
    localparam int CntBits = $clog2(NumBits + 1);

    logic [NumBits-1:0]   q_reg;
    logic [CoordBits:0]   r_reg;
    logic [CoordBits-1:0] d_reg;
    logic [CntBits-1:0]   cnt_reg;
    logic                 busy_reg;
    logic [CoordBits+1:0] trial;

    assign trial = {r_reg, q_reg[NumBits-1]} - {2'b0, d_reg};
    assign done  = busy_reg && (cnt_reg == '0);
    assign quo   = q_reg[CoordBits-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= NumBits[CntBits-1:0];
            q_reg    <= num;
            r_reg    <= '0;
            d_reg    <= den;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!trial[CoordBits+1])
                begin
                    r_reg <= trial[CoordBits:0];
                    q_reg <= {q_reg[NumBits-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[CoordBits-1:0], q_reg[NumBits-1]};
                    q_reg <= {q_reg[NumBits-2:0], 1'b0};
                end
            end
        end
    end

endmodule

@@ rtl/spf_back.sv @@
// Execution side: vertex store, edge walk, crossing sort and span output.
module spf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  spf_pkg::cmd_t q_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [spf_pkg::CoordBits-1:0] span_y,
    output logic [spf_pkg::CoordBits:0]   span_x_start,
    output logic [spf_pkg::CoordBits-1:0] span_x_end,
    output logic          span_valid,
    output logic          last_span
);
    import spf_pkg::*;

    localparam int SpanBits = $clog2(SpanLimit + 1);

    vertex_t              vmem [MaxVertices];
    logic [VcntBits-1:0]  vcnt_reg;
    coord_t               bl_reg, br_reg, blo_reg, bhi_reg;
    coord_t               xs_reg [MaxVertices];
    logic [VcntBits-1:0]  k_reg, k_next;
    logic [VcntBits-1:0]  e_reg, e_next;
    logic [VcntBits-1:0]  s_reg, s_next;
    logic [SpanBits-1:0]  p_reg, p_next;
    logic [SpanBits-1:0]  np_reg, np_next;
    logic                 sphase_reg, sphase_next;
    coord_t               sy_reg;
    state_t               st_reg, st_next;
    vertex_t              va, vb;
    logic [VidxBits-1:0]  nidx;
    coord_t               lo, hi, den;
    logic                 in_span;
    logic [2*CoordBits:0] num;
    logic                 div_start, div_done;
    coord_t               quo;
    logic                 direct;
    coord_t               dx;
    logic                 push_x;
    coord_t               push_v;
    logic                 ov_reg;
    logic [CoordBits-1:0] oy_reg, oe_reg;
    logic [CoordBits:0]   os_reg;
    logic                 osv_reg, ol_reg;
    logic                 emit;

    assign va   = vmem[e_reg[VidxBits-1:0]];
    assign nidx = (e_reg + 1'b1 < vcnt_reg) ? VidxBits'(e_reg + 1'b1) : '0;
    assign vb   = vmem[nidx];
    assign lo   = (va.y < vb.y) ? va.y : vb.y;
    assign hi   = (va.y < vb.y) ? vb.y : va.y;
    assign in_span = (sy_reg >= lo) && (sy_reg <= hi);
    assign direct  = (va.x == vb.x) || (va.y == vb.y);
    assign dx      = (va.x < vb.x) ? va.x : vb.x;

    // exact x = (x1*(y2-y) + x2*(y-y1)) / (y2-y1) with y1 < y2 oriented
    logic [2*CoordBits-1:0] ta, tb;
    vertex_t                lv, hv;
    coord_t                 dyh, dyl;
    assign lv  = (va.y < vb.y) ? va : vb;
    assign hv  = (va.y < vb.y) ? vb : va;
    assign den = hv.y - lv.y;
    assign dyh = hv.y - sy_reg;
    assign dyl = sy_reg - lv.y;

    logic [CoordBits-1:0] den_reg;
    always_ff @(posedge clk)
    begin
        ta      <= {{CoordBits{1'b0}}, lv.x} * {{CoordBits{1'b0}}, dyh};
        tb      <= {{CoordBits{1'b0}}, hv.x} * {{CoordBits{1'b0}}, dyl};
        den_reg <= den;
    end
    assign num = {1'b0, ta} + {1'b0, tb};

    spf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign q_ready = (st_reg == ST_IDLE);
    assign emit    = !ov_reg || out_ready;

    logic [VcntBits-1:0] np_full;
    assign np_full = {1'b0, k_reg[VcntBits-1:1]};

    always_comb
    begin
        st_next     = st_reg;
        k_next      = k_reg;
        e_next      = e_reg;
        s_next      = s_reg;
        p_next      = p_reg;
        np_next     = np_reg;
        sphase_next = sphase_reg;
        div_start   = 1'b0;
        push_x      = 1'b0;
        push_v      = dx;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.op == OP_FILL)
                begin
                    k_next = '0;
                    e_next = '0;
                    if (q_cmd.sy > blo_reg && q_cmd.sy < bhi_reg && vcnt_reg != '0)
                    begin
                        st_next = ST_EDGE;
                    end
                    else
                    begin
                        st_next = ST_SORT;
                        s_next  = '0;
                    end
                end
            end
            ST_EDGE:
            begin
                if (e_reg >= vcnt_reg)
                begin
                    st_next     = ST_SORT;
                    s_next      = '0;
                    sphase_next = 1'b0;
                end
                else if (!in_span)
                begin
                    e_next = e_reg + 1'b1;
                end
                else if (direct)
                begin
                    push_x = 1'b1;
                    e_next = e_reg + 1'b1;
                end
                else
                begin
                    st_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                st_next   = ST_DIV;
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    push_x  = 1'b1;
                    push_v  = quo;
                    e_next  = e_reg + 1'b1;
                    st_next = ST_EDGE;
                end
            end
            ST_SORT:
            begin
                // odd-even transposition, k passes
                if (s_reg >= k_reg)
                begin
                    st_next = ST_EMIT;
                    p_next  = '0;
                    np_next = (np_full > VcntBits'(SpanLimit)) ? SpanBits'(SpanLimit)
                            : SpanBits'(np_full);
                end
                else
                begin
                    s_next      = s_reg + 1'b1;
                    sphase_next = ~sphase_reg;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    p_next = p_reg + 1'b1;
                    if (np_reg == '0 || p_reg + 1'b1 == np_reg)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && q_valid && q_cmd.op == OP_APPEND
            && vcnt_reg < VcntBits'(MaxVertices))
        begin
            vmem[vcnt_reg[VidxBits-1:0]] <= '{x: q_cmd.vx, y: q_cmd.vy};
        end
        if (push_x)
        begin
            xs_reg[k_reg[VidxBits-1:0]] <= push_v;
        end
        if (st_reg == ST_SORT && s_reg < k_reg)
        begin
            for (int i = 0; i < MaxVertices - 1; i++)
            begin
                if ((i % 2 == 0) == !sphase_reg && VcntBits'(i + 1) < k_reg
                    && xs_reg[i] > xs_reg[i+1])
                begin
                    xs_reg[i]   <= xs_reg[i+1];
                    xs_reg[i+1] <= xs_reg[i];
                end
            end
        end
        if (q_ready && q_valid)
        begin
            sy_reg <= q_cmd.sy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            vcnt_reg   <= '0;
            bl_reg     <= '0;
            br_reg     <= '0;
            blo_reg    <= '0;
            bhi_reg    <= '0;
            k_reg      <= '0;
            e_reg      <= '0;
            s_reg      <= '0;
            p_reg      <= '0;
            np_reg     <= '0;
            sphase_reg <= 1'b0;
            ov_reg     <= 1'b0;
            oy_reg     <= '0;
            os_reg     <= '0;
            oe_reg     <= '0;
            osv_reg    <= 1'b0;
            ol_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            e_reg      <= e_next;
            s_reg      <= s_next;
            p_reg      <= p_next;
            np_reg     <= np_next;
            sphase_reg <= sphase_next;
            k_reg      <= push_x ? k_reg + 1'b1 : k_next;
            if (st_reg == ST_IDLE && q_valid)
            begin
                if (q_cmd.op == OP_CLEAR)
                begin
                    vcnt_reg <= '0;
                    bl_reg   <= '0;
                    br_reg   <= '0;
                    blo_reg  <= '0;
                    bhi_reg  <= '0;
                end
                else if (q_cmd.op == OP_APPEND && vcnt_reg < VcntBits'(MaxVertices))
                begin
                    vcnt_reg <= vcnt_reg + 1'b1;
                    if (vcnt_reg == '0)
                    begin
                        bl_reg  <= q_cmd.vx;
                        br_reg  <= q_cmd.vx;
                        blo_reg <= q_cmd.vy;
                        bhi_reg <= q_cmd.vy;
                    end
                    else
                    begin
                        if (q_cmd.vx < bl_reg)  bl_reg  <= q_cmd.vx;
                        if (q_cmd.vx > br_reg)  br_reg  <= q_cmd.vx;
                        if (q_cmd.vy < blo_reg) blo_reg <= q_cmd.vy;
                        if (q_cmd.vy > bhi_reg) bhi_reg <= q_cmd.vy;
                    end
                end
            end
            if (st_reg == ST_EMIT && emit)
            begin
                ov_reg <= 1'b1;
                oy_reg <= sy_reg;
                if (np_reg == '0)
                begin
                    os_reg  <= '0;
                    oe_reg  <= '0;
                    osv_reg <= 1'b0;
                    ol_reg  <= 1'b1;
                end
                else
                begin
                    os_reg  <= {1'b0, xs_reg[{p_reg[SpanBits-2:0], 1'b0}]} + 1'b1;
                    oe_reg  <= xs_reg[{p_reg[SpanBits-2:0], 1'b1}];
                    osv_reg <= 1'b1;
                    ol_reg  <= (p_reg + 1'b1 == np_reg);
                end
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign span_y       = oy_reg;
    assign span_x_start = os_reg;
    assign span_x_end   = oe_reg;
    assign span_valid   = osv_reg;
    assign last_span    = ol_reg;

endmodule

@@ tb/scanline_polygon_span_fill_tb.sv @@
// Testbench for the scanline polygon span filler against a span predictor.
`timescale 1ns / 100ps

module scanline_polygon_span_fill_tb;
    import spf_pkg::*;

    typedef struct packed {
        logic [9:0]  y;
        logic [10:0] xs;
        logic [9:0]  xe;
        logic        sv;
        logic        lst;
    } span_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    span_t       span_q[$];
    logic [9:0]  poly_x[MaxVertices];
    logic [9:0]  poly_y[MaxVertices];
    int          poly_n;
    int          lo_y;
    int          hi_y;
    int          errors;
    int          idle_cycles;
    int          fills_sent;
    int          spans_seen;
    int          out_wait;

    scanline_polygon_span_fill uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    task automatic predict_spans(input op_t op, input int vx, input int vy, input int sy);
        longint xc[$];
        longint ax, ay, bx, by, num, den, t;
        int     pairs;
        span_t  s;
        if (op == OP_CLEAR)
        begin
            poly_n = 0;
            lo_y = 0;
            hi_y = 0;
        end
        else if (op == OP_APPEND)
        begin
            if (poly_n < MaxVertices)
            begin
                poly_x[poly_n] = vx[9:0];
                poly_y[poly_n] = vy[9:0];
                if (poly_n == 0)
                begin
                    lo_y = vy;
                    hi_y = vy;
                end
                else
                begin
                    if (vy < lo_y) lo_y = vy;
                    if (vy > hi_y) hi_y = vy;
                end
                poly_n++;
            end
        end
        else if (op == OP_FILL)
        begin
            if (sy > lo_y && sy < hi_y)
            begin
                for (int i = 0; i < poly_n; i++)
                begin
                    ax = poly_x[i];
                    ay = poly_y[i];
                    bx = poly_x[(i + 1 < poly_n) ? i + 1 : 0];
                    by = poly_y[(i + 1 < poly_n) ? i + 1 : 0];
                    if (sy < ((ay < by) ? ay : by) || sy > ((ay < by) ? by : ay)) continue;
                    if (ax == bx) xc.push_back(ax);
                    else if (ay == by) xc.push_back((ax < bx) ? ax : bx);
                    else
                    begin
                        den = by - ay;
                        num = bx * den + (sy - by) * (bx - ax);
                        if (den < 0)
                        begin
                            den = -den;
                            num = -num;
                        end
                        if (num < 0) num = 0;
                        xc.push_back(num / den);
                    end
                end
            end
            xc.sort();
            pairs = xc.size() / 2;
            if (pairs > SpanLimit) pairs = SpanLimit;
            if (pairs == 0)
            begin
                s = '{y: sy[9:0], xs: '0, xe: '0, sv: 1'b0, lst: 1'b1};
                span_q.push_back(s);
            end
            for (int i = 0; i < pairs; i++)
            begin
                t = xc[2 * i] + 1;
                s.y = sy[9:0];
                s.xs = t[10:0];
                s.xe = xc[2 * i + 1][9:0];
                s.sv = 1'b1;
                s.lst = (i + 1 == pairs);
                span_q.push_back(s);
            end
            fills_sent++;
        end
    endtask

    task automatic send_word(input op_t op, input int vx, input int vy, input int sy);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {sy[9:0], vy[9:0], vx[9:0], op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_spans(op, vx, vy, sy);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (span_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic test_directed;
        send_word(OP_FILL, 0, 0, 5);
        send_word(OP_APPEND, 1023, 1023, 0);
        send_word(OP_APPEND, 0, 0, 0);
        send_word(OP_FILL, 0, 0, 0);
        send_word(OP_APPEND, 0, 1023, 0);
        send_word(OP_FILL, 0, 0, 512);
        send_word(OP_FILL, 0, 0, 1023);
        send_word(OP_NONE, 1023, 1023, 1023);
        send_word(OP_CLEAR, 0, 0, 0);
        send_word(OP_APPEND, 100, 100, 0);
        send_word(OP_APPEND, 300, 100, 0);
        send_word(OP_APPEND, 300, 300, 0);
        send_word(OP_APPEND, 200, 200, 0);
        send_word(OP_APPEND, 100, 300, 0);
        send_word(OP_FILL, 0, 0, 200);
        send_word(OP_FILL, 0, 0, 250);
        send_word(OP_FILL, 0, 0, 100);
        send_word(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_comb;
        send_word(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < MaxVertices + 2; i++)
            send_word(OP_APPEND, i * 60, (i % 2) ? 1000 : 10, 0);
        send_word(OP_FILL, 0, 0, 500);
        send_word(OP_FILL, 0, 0, 999);
        wait_drained();
    endtask

    task automatic test_random;
        int n, nv, big;
        n = 0;
        while (n < 260)
        begin
            send_word(OP_CLEAR, 0, 0, 0);
            nv = $urandom_range(3, MaxVertices + 1);
            big = $urandom_range(0, 3);
            for (int i = 0; i < nv; i++)
            begin
                if (big == 0)
                    send_word(OP_APPEND, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
                else
                    send_word(OP_APPEND, $urandom_range(0, 63), $urandom_range(0, 63), 0);
                n++;
            end
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(OP_NONE, $urandom, $urandom, $urandom);
                send_word(OP_FILL, 0, 0, (big == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 64));
                n++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                w = $urandom_range(0, 9);
                m_axis_tready <= (w == 0);
                out_wait <= (w == 0) ? 0 : w - 1;
            end
            else if (!m_axis_tready)
            begin
                if (out_wait == 0)
                    m_axis_tready <= 1'b1;
                else
                    out_wait <= out_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        span_t exp_s;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            spans_seen++;
            if (span_q.size() == 0)
            begin
                $error("span with no expectation: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_s = span_q.pop_front();
                if (m_axis_tdata[9:0] !== exp_s.y)
                begin
                    $error("span_y exp %0d got %0d", exp_s.y, m_axis_tdata[9:0]);
                    errors++;
                end
                if (m_axis_tdata[20:10] !== exp_s.xs)
                begin
                    $error("span_x_start exp %0d got %0d", exp_s.xs, m_axis_tdata[20:10]);
                    errors++;
                end
                if (m_axis_tdata[30:21] !== exp_s.xe)
                begin
                    $error("span_x_end exp %0d got %0d", exp_s.xe, m_axis_tdata[30:21]);
                    errors++;
                end
                if (m_axis_tuser !== exp_s.sv)
                begin
                    $error("span_valid exp %0d got %0d", exp_s.sv, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_s.lst)
                begin
                    $error("last_span exp %0d got %0d", exp_s.lst, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("watchdog: no progress");
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        errors = 0;
        idle_cycles = 0;
        fills_sent = 0;
        spans_seen = 0;
        out_wait = 0;
        poly_n = 0;
        lo_y = 0;
        hi_y = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_comb();
        test_random();
        wait_drained();
        $display("covered %0d fill requests, %0d span words, clear/append/full/ignored ops",
                 fills_sent, spans_seen);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
